### sv/sc1d_pkg.sv
// Shared constants, types and the extended-key table for the set 1 scan code decoder.
`timescale 1ns / 1ps

package sc1d_pkg;

  localparam int unsigned StateW = 3;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CodeW  = 7;

  localparam logic [StateW-1:0] ST_IDLE  = 3'd0;
  localparam logic [StateW-1:0] ST_E0    = 3'd1;
  localparam logic [StateW-1:0] ST_E1    = 3'd2;
  localparam logic [StateW-1:0] ST_E1_1D = 3'd3;
  localparam logic [StateW-1:0] ST_E1_9D = 3'd4;

  localparam logic [ByteW-1:0] BYTE_E0         = 8'hE0;
  localparam logic [ByteW-1:0] BYTE_E1         = 8'hE1;
  localparam logic [ByteW-1:0] PLAIN_MAX       = 8'hD8;
  localparam logic [ByteW-1:0] FAKE_LS_MAKE    = 8'h2A;
  localparam logic [ByteW-1:0] FAKE_LS_BREAK   = 8'hAA;
  localparam logic [ByteW-1:0] FAKE_RS_MAKE    = 8'h36;
  localparam logic [ByteW-1:0] FAKE_RS_BREAK   = 8'hB6;
  localparam logic [ByteW-1:0] PAUSE_MID_MAKE  = 8'h1D;
  localparam logic [ByteW-1:0] PAUSE_MID_BREAK = 8'h9D;
  localparam logic [ByteW-1:0] PAUSE_END_MAKE  = 8'h45;
  localparam logic [ByteW-1:0] PAUSE_END_BREAK = 8'hC5;
  localparam logic [CodeW-1:0] CODE_PAUSE      = 7'h48;
  localparam logic [CodeW-1:0] CODE_NONE       = 7'h00;

  typedef struct packed {
    logic              emit;
    logic [CodeW-1:0]  key_code;
    logic              is_press;
    logic [StateW-1:0] state_nxt;
  } sc1d_dec_t;

  // Extended-key map, indexed by the E0-prefixed byte with bit 7 cleared.
  // A result of CODE_NONE means the byte has no mapping.
  function automatic logic [CodeW-1:0] ext_map(input logic [CodeW-1:0] idx);
    logic [CodeW-1:0] res;
    res = CODE_NONE;
    case (idx)
      7'h1C: res = 7'h6F;
      7'h1D: res = 7'h7A;
      7'h35: res = 7'h7F;
      7'h37: res = 7'h54;
      7'h38: res = 7'h7C;
      7'h45: res = 7'h48;
      7'h46: res = 7'h48;
      7'h47: res = 7'h74;
      7'h48: res = 7'h60;
      7'h49: res = 7'h77;
      7'h4B: res = 7'h61;
      7'h4D: res = 7'h63;
      7'h4F: res = 7'h75;
      7'h50: res = 7'h62;
      7'h51: res = 7'h78;
      7'h52: res = 7'h71;
      7'h53: res = 7'h72;
      7'h5B: res = 7'h5A;
      7'h5C: res = 7'h5B;
      7'h5D: res = 7'h5C;
      7'h5E: res = 7'h70;
      7'h5F: res = 7'h79;
      7'h63: res = 7'h7B;
      default: res = CODE_NONE;
    endcase
    return res;
  endfunction

endpackage

### sv/sc1d_decode.sv
// Combinational decode of one scan byte against the current prefix state.
`timescale 1ns / 1ps

module sc1d_decode (
  input  logic [sc1d_pkg::StateW-1:0] state,
  input  logic [sc1d_pkg::ByteW-1:0]  scan_byte,
  output sc1d_pkg::sc1d_dec_t         dec
);
  import sc1d_pkg::*;

  logic [CodeW-1:0] ext_code;

  assign ext_code = ext_map(scan_byte[CodeW-1:0]);

  always_comb begin
    dec           = '0;
    dec.state_nxt = ST_IDLE;
    dec.key_code  = CODE_NONE;
    unique case (state)
      ST_IDLE: begin
        if (scan_byte == BYTE_E0) begin
          dec.state_nxt = ST_E0;
        end else if (scan_byte == BYTE_E1) begin
          dec.state_nxt = ST_E1;
        end else if (scan_byte <= PLAIN_MAX) begin
          dec.emit     = 1'b1;
          dec.key_code = scan_byte[CodeW-1:0];
          dec.is_press = ~scan_byte[ByteW-1];
        end
      end
      ST_E0: begin
        // Fake shifts around extended keys are discarded.
        if (scan_byte != FAKE_LS_MAKE && scan_byte != FAKE_LS_BREAK &&
            scan_byte != FAKE_RS_MAKE && scan_byte != FAKE_RS_BREAK &&
            ext_code != CODE_NONE) begin
          dec.emit     = 1'b1;
          dec.key_code = ext_code;
          dec.is_press = ~scan_byte[ByteW-1];
        end
      end
      ST_E1: begin
        if (scan_byte == PAUSE_MID_MAKE) begin
          dec.state_nxt = ST_E1_1D;
        end else if (scan_byte == PAUSE_MID_BREAK) begin
          dec.state_nxt = ST_E1_9D;
        end
      end
      ST_E1_1D: begin
        if (scan_byte == PAUSE_END_MAKE) begin
          dec.emit     = 1'b1;
          dec.key_code = CODE_PAUSE;
          dec.is_press = 1'b1;
        end
      end
      ST_E1_9D: begin
        if (scan_byte == PAUSE_END_BREAK) begin
          dec.emit     = 1'b1;
          dec.key_code = CODE_PAUSE;
          dec.is_press = 1'b0;
        end
      end
      default: begin
        dec.state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### sv/scancode_set1_decoder.sv
// Top level of the scan code set 1 decoder: input stage, prefix state and result register.
`timescale 1ns / 1ps
// Path: a byte accepted into stage one is decoded there against the prefix state, and its key event
// is registered into the result register that drives the out_ ports once stage one can advance.
// Throughput: one input beat per cycle; the only limit is the result side holding out_stall.
// Bytes that yield no event (prefixes, fake shifts, unmapped codes) are consumed silently.
// Reset (rst_n low, synchronous) empties both stages and returns the prefix state to idle.

module scancode_set1_decoder (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [sc1d_pkg::ByteW-1:0]  in_scan_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [sc1d_pkg::CodeW-1:0]  out_key_code,
  output logic                        out_is_press
);
  import sc1d_pkg::*;

  // Stage one holds the accepted byte. Stage two holds a finished key event.
  logic              s1_valid_r;
  logic              s1_valid_nxt;
  logic [ByteW-1:0]  s1_byte_r;
  logic [StateW-1:0] state_r;
  logic [StateW-1:0] state_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [CodeW-1:0]  out_key_code_r;
  logic              out_is_press_r;
  logic              advance;
  logic              in_accept;
  sc1d_dec_t         dec;

  sc1d_decode u_decode (
    .state     (state_r),
    .scan_byte (s1_byte_r),
    .dec       (dec)
  );

  // The result register may be refilled whenever it is empty or its beat is
  // being taken this cycle; stage one moves forward on the same condition.
  assign advance   = ~out_valid_r | ~out_stall;
  assign in_stall  = s1_valid_r & ~advance;
  assign in_accept = in_valid & ~in_stall;

  always_comb begin
    // Stage one fills on any input beat, including one taken while the
    // result side is stalled and stage one was empty. Otherwise it keeps
    // its byte only while that byte cannot move on.
    s1_valid_nxt  = in_accept | (s1_valid_r & ~advance);
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (advance) begin
      // A held byte is decoded exactly once, as it leaves stage one.
      out_valid_nxt = s1_valid_r & dec.emit;
      if (s1_valid_r) begin
        state_nxt = dec.state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset; they load only on a moving beat.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte_r <= in_scan_byte;
    end
    if (advance && s1_valid_r && dec.emit) begin
      out_key_code_r <= dec.key_code;
      out_is_press_r <= dec.is_press;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_key_code = out_key_code_r;
  assign out_is_press = out_is_press_r;

endmodule
